[rtl/core/sdpe_pkg.sv]
// Shared widths, defaults, cell control type and width helpers for the disk point enumerator.
`default_nettype none

package sdpe_pkg;

    // Fixed field widths of the external interface.
    localparam int CFG_W = 10;
    localparam int OFF_W = 6;
    localparam int GRP_W = 10;

    // Default disk size and reset value of the distance bound.
    localparam int MAX_RADIUS_DEF = 31;
    localparam logic [CFG_W-1:0] MAX_SQ_RESET = 10'd4;

    // Broadcast control for one cell of the row chain.
    typedef struct packed {
        logic clear;
        logic step;
    } cell_ctrl_t;

    // Bits needed for a row index over 2*R+1 rows.
    function automatic int row_w(input int max_radius);
        return $clog2(2 * max_radius + 1);
    endfunction

    // Bits needed for a column magnitude that can run one past the radius.
    function automatic int mag_w(input int max_radius);
        return $clog2(max_radius + 2);
    endfunction

    // Bits needed for a candidate squared distance, never narrower than the bound.
    function automatic int sq_w(input int max_radius);
        int w;
        w = $clog2(2 * (max_radius + 1) * (max_radius + 1) + 1);
        return (w > CFG_W) ? w : CFG_W;
    endfunction

endpackage

`default_nettype wire

[rtl/core/sdpe_cell.sv]
// One row cell: holds the row frontier and passes the running minimum to its neighbor.
`default_nettype none

module sdpe_cell
    import sdpe_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int ROW_IDX    = 0
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  cell_ctrl_t                       ctrl,
    input  wire  [CFG_W-1:0]                 max_sq_dist,
    input  wire                              up_valid,
    input  wire  [sq_w(MAX_RADIUS)-1:0]      up_sq,
    input  wire  [row_w(MAX_RADIUS)-1:0]     up_row,
    input  wire  [mag_w(MAX_RADIUS)-1:0]     up_mag,
    input  wire                              up_neg,
    output logic                             best_valid,
    output logic [sq_w(MAX_RADIUS)-1:0]      best_sq,
    output logic [row_w(MAX_RADIUS)-1:0]     best_row,
    output logic [mag_w(MAX_RADIUS)-1:0]     best_mag,
    output logic                             best_neg,
    output logic                             cand_ok
);

    localparam int RowW   = row_w(MAX_RADIUS);
    localparam int MagW   = mag_w(MAX_RADIUS);
    localparam int SqW    = sq_w(MAX_RADIUS);
    localparam int RowOff = ROW_IDX - MAX_RADIUS;
    localparam int RowSq  = RowOff * RowOff;
    localparam logic [SqW-1:0]  ROW_SQ  = SqW'(RowSq);
    localparam logic [RowW-1:0] ROW_ID  = RowW'(ROW_IDX);
    localparam logic [MagW-1:0] MAG_MAX = MagW'(MAX_RADIUS);

    logic [MagW-1:0] mag_reg, mag_next;
    logic            neg_reg, neg_next;
    logic [SqW-1:0]  sq_reg, sq_next;

    logic            best_valid_reg, best_valid_next;
    logic [SqW-1:0]  best_sq_reg, best_sq_next;
    logic [RowW-1:0] best_row_reg, best_row_next;
    logic [MagW-1:0] best_mag_reg, best_mag_next;
    logic            best_neg_reg, best_neg_next;

    logic [SqW-1:0]  max_sq_ext;
    logic [SqW-1:0]  sq_incr;
    logic            take;

    // The candidate of this row is inside the disk.
    assign max_sq_ext = SqW'(max_sq_dist);
    assign cand_ok    = (mag_reg <= MAG_MAX) && (sq_reg <= max_sq_ext);

    // Keep the upstream best unless this row is strictly closer.
    assign take = cand_ok && (!up_valid || (sq_reg < up_sq));

    always_comb
    begin
        if (take)
        begin
            best_valid_next = 1'b1;
            best_sq_next    = sq_reg;
            best_row_next   = ROW_ID;
            best_mag_next   = mag_reg;
            best_neg_next   = neg_reg;
        end
        else
        begin
            best_valid_next = up_valid;
            best_sq_next    = up_sq;
            best_row_next   = up_row;
            best_mag_next   = up_mag;
            best_neg_next   = up_neg;
        end
    end

    // Frontier advance: zero column, then negative, then positive, then next magnitude.
    // Moving from magnitude m to m+1 adds 2m+1 to the squared distance.
    assign sq_incr = SqW'({mag_reg, 1'b1});

    always_comb
    begin
        mag_next = mag_reg;
        neg_next = neg_reg;
        sq_next  = sq_reg;
        if (ctrl.clear)
        begin
            mag_next = '0;
            neg_next = 1'b0;
            sq_next  = ROW_SQ;
        end
        else if (ctrl.step)
        begin
            if ((mag_reg == '0) || neg_reg)
            begin
                mag_next = mag_reg + MagW'(1);
                neg_next = 1'b0;
                sq_next  = sq_reg + sq_incr;
            end
            else
            begin
                neg_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg        <= '0;
            neg_reg        <= 1'b0;
            sq_reg         <= ROW_SQ;
            best_valid_reg <= 1'b0;
            best_sq_reg    <= '0;
            best_row_reg   <= '0;
            best_mag_reg   <= '0;
            best_neg_reg   <= 1'b0;
        end
        else
        begin
            mag_reg        <= mag_next;
            neg_reg        <= neg_next;
            sq_reg         <= sq_next;
            best_valid_reg <= best_valid_next;
            best_sq_reg    <= best_sq_next;
            best_row_reg   <= best_row_next;
            best_mag_reg   <= best_mag_next;
            best_neg_reg   <= best_neg_next;
        end
    end

    assign best_valid = best_valid_reg;
    assign best_sq    = best_sq_reg;
    assign best_row   = best_row_reg;
    assign best_mag   = best_mag_reg;
    assign best_neg   = best_neg_reg;

endmodule

`default_nettype wire

[rtl/core/sorted_disk_point_enumerator.sv]
// Flow: an accepted request sweeps the running minimum through the 2*MAX_RADIUS+1 row cells,
// then passes the select, last check and output steps; an empty answer for a stranded walk skips
// the last check, and a request after the end goes straight to the output step. No new request
// is accepted until the result has left the sequencer, and an output stall holds it in the output
// step. Reset: asynchronous, active low; rows return to the center, the bound returns to 4, and
// the block is ready with no clearing pass.
// Top level of the sorted disk point enumerator.
`default_nettype none

module sorted_disk_point_enumerator
    import sdpe_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire  [CFG_W-1:0]        cfg_data,
    input  wire                     in_valid,
    output logic                    in_stall,
    input  wire                     restart,
    output logic                    out_valid,
    input  wire                     out_stall,
    output logic signed [OFF_W-1:0] row_offset,
    output logic signed [OFF_W-1:0] col_offset,
    output logic [CFG_W-1:0]        sq_dist,
    output logic [GRP_W-1:0]        group_index,
    output logic                    group_start,
    output logic                    last_point,
    output logic                    point_valid
);

    localparam int ROWS = 2 * MAX_RADIUS + 1;
    localparam int RowW = row_w(MAX_RADIUS);
    localparam int MagW = mag_w(MAX_RADIUS);
    localparam int SqW  = sq_w(MAX_RADIUS);
    localparam int CntW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [CntW-1:0] CNT_LAST = CntW'(ROWS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SWEEP = 3'd1;
    localparam logic [2:0] ST_PICK  = 3'd2;
    localparam logic [2:0] ST_LAST  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic [CFG_W-1:0] max_sq_reg, max_sq_next;
    logic             started_reg, started_next;
    logic             finished_reg, finished_next;
    logic [CFG_W-1:0] prev_sq_reg, prev_sq_next;
    logic [GRP_W-1:0] group_reg, group_next;

    logic signed [OFF_W-1:0] res_row_reg, res_row_next;
    logic signed [OFF_W-1:0] res_col_reg, res_col_next;
    logic [CFG_W-1:0]        res_sq_reg, res_sq_next;
    logic [GRP_W-1:0]        res_grp_reg, res_grp_next;
    logic                    res_gstart_reg, res_gstart_next;
    logic                    res_last_reg, res_last_next;
    logic                    res_valid_reg, res_valid_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [OFF_W-1:0] row_offset_reg, row_offset_next;
    logic signed [OFF_W-1:0] col_offset_reg, col_offset_next;
    logic [CFG_W-1:0]        sq_dist_reg, sq_dist_next;
    logic [GRP_W-1:0]        group_index_reg, group_index_next;
    logic                    group_start_reg, group_start_next;
    logic                    last_point_reg, last_point_next;
    logic                    point_valid_reg, point_valid_next;

    // Chain links: index 0 feeds the first cell, index ROWS is the tail.
    logic            chain_valid [0:ROWS];
    logic [SqW-1:0]  chain_sq    [0:ROWS];
    logic [RowW-1:0] chain_row   [0:ROWS];
    logic [MagW-1:0] chain_mag   [0:ROWS];
    logic            chain_neg   [0:ROWS];
    cell_ctrl_t      cell_ctrl   [0:ROWS-1];
    logic [ROWS-1:0] cell_ok;

    logic            clear_all;
    logic            step_en;
    logic            in_acc;
    logic            out_free;
    logic            any_ok;
    logic            tail_valid;
    logic [SqW-1:0]  tail_sq;
    logic [RowW-1:0] tail_row;
    logic [MagW-1:0] tail_mag;
    logic            tail_neg;
    logic [CFG_W-1:0]        tail_sq10;
    logic signed [RowW:0]    row_s;
    logic [OFF_W-1:0]        col_mag;
    logic signed [OFF_W-1:0] col_val;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // The first cell sees no upstream candidate.
    assign chain_valid[0] = 1'b0;
    assign chain_sq[0]    = '0;
    assign chain_row[0]   = '0;
    assign chain_mag[0]   = '0;
    assign chain_neg[0]   = 1'b0;

    // Row cell chain, one cell per row offset.
    genvar gi;
    generate
        for (gi = 0; gi < ROWS; gi++)
        begin : g_cell
            assign cell_ctrl[gi] = '{clear: clear_all,
                                     step:  step_en && (tail_row == RowW'(gi))};

            sdpe_cell #(
                .MAX_RADIUS (MAX_RADIUS),
                .ROW_IDX    (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cell_ctrl[gi]),
                .max_sq_dist (max_sq_reg),
                .up_valid    (chain_valid[gi]),
                .up_sq       (chain_sq[gi]),
                .up_row      (chain_row[gi]),
                .up_mag      (chain_mag[gi]),
                .up_neg      (chain_neg[gi]),
                .best_valid  (chain_valid[gi+1]),
                .best_sq     (chain_sq[gi+1]),
                .best_row    (chain_row[gi+1]),
                .best_mag    (chain_mag[gi+1]),
                .best_neg    (chain_neg[gi+1]),
                .cand_ok     (cell_ok[gi])
            );
        end
    endgenerate

    // Minimum at the end of the chain, and whether any row still has a point.
    assign tail_valid = chain_valid[ROWS];
    assign tail_sq    = chain_sq[ROWS];
    assign tail_row   = chain_row[ROWS];
    assign tail_mag   = chain_mag[ROWS];
    assign tail_neg   = chain_neg[ROWS];
    assign any_ok     = |cell_ok;

    // Point coordinates; any point in the disk lies within the output range.
    assign tail_sq10 = CFG_W'(tail_sq);
    assign row_s     = $signed({1'b0, tail_row}) - $signed((RowW+1)'(MAX_RADIUS));
    assign col_mag   = OFF_W'(tail_mag);

    always_comb
    begin
        if (tail_mag == '0)
        begin
            col_val = '0;
        end
        else if (!tail_neg)
        begin
            col_val = -$signed(col_mag);
        end
        else
        begin
            col_val = $signed(col_mag);
        end
    end

    // Sequencer: sweep, select and update, last check, output.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        started_next    = started_reg;
        finished_next   = finished_reg;
        prev_sq_next    = prev_sq_reg;
        group_next      = group_reg;
        res_row_next    = res_row_reg;
        res_col_next    = res_col_reg;
        res_sq_next     = res_sq_reg;
        res_grp_next    = res_grp_reg;
        res_gstart_next = res_gstart_reg;
        res_last_next   = res_last_reg;
        res_valid_next  = res_valid_reg;
        clear_all       = 1'b0;
        step_en         = 1'b0;

        out_valid_next   = out_valid_reg && out_stall;
        row_offset_next  = row_offset_reg;
        col_offset_next  = col_offset_reg;
        sq_dist_next     = sq_dist_reg;
        group_index_next = group_index_reg;
        group_start_next = group_start_reg;
        last_point_next  = last_point_reg;
        point_valid_next = point_valid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cnt_next = '0;
                    if (restart)
                    begin
                        clear_all     = 1'b1;
                        started_next  = 1'b0;
                        finished_next = 1'b0;
                        prev_sq_next  = '0;
                        group_next    = '0;
                        state_next    = ST_SWEEP;
                    end
                    else if (finished_reg)
                    begin
                        res_row_next    = '0;
                        res_col_next    = '0;
                        res_sq_next     = '0;
                        res_grp_next    = '0;
                        res_gstart_next = 1'b0;
                        res_last_next   = 1'b0;
                        res_valid_next  = 1'b0;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SWEEP;
                    end
                end
            end

            ST_SWEEP:
            begin
                cnt_next = cnt_reg + CntW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_PICK;
                end
            end

            ST_PICK:
            begin
                if (tail_valid)
                begin
                    step_en        = 1'b1;
                    res_row_next   = OFF_W'(row_s);
                    res_col_next   = col_val;
                    res_sq_next    = tail_sq10;
                    res_valid_next = 1'b1;
                    prev_sq_next   = tail_sq10;
                    if (!started_reg)
                    begin
                        started_next    = 1'b1;
                        group_next      = '0;
                        res_grp_next    = '0;
                        res_gstart_next = 1'b1;
                    end
                    else if (tail_sq10 != prev_sq_reg)
                    begin
                        group_next      = group_reg + GRP_W'(1);
                        res_grp_next    = group_reg + GRP_W'(1);
                        res_gstart_next = 1'b1;
                    end
                    else
                    begin
                        res_grp_next    = group_reg;
                        res_gstart_next = 1'b0;
                    end
                    state_next = ST_LAST;
                end
                else
                begin
                    finished_next   = 1'b1;
                    res_row_next    = '0;
                    res_col_next    = '0;
                    res_sq_next     = '0;
                    res_grp_next    = '0;
                    res_gstart_next = 1'b0;
                    res_last_next   = 1'b0;
                    res_valid_next  = 1'b0;
                    state_next      = ST_EMIT;
                end
            end

            ST_LAST:
            begin
                finished_next = !any_ok;
                res_last_next = !any_ok;
                state_next    = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    row_offset_next  = res_row_reg;
                    col_offset_next  = res_col_reg;
                    sq_dist_next     = res_sq_reg;
                    group_index_next = res_grp_reg;
                    group_start_next = res_gstart_reg;
                    last_point_next  = res_last_reg;
                    point_valid_next = res_valid_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Distance bound register.
    always_comb
    begin
        max_sq_next = max_sq_reg;
        if (cfg_valid && cfg_ready)
        begin
            max_sq_next = cfg_data;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            max_sq_reg    <= MAX_SQ_RESET;
            started_reg   <= 1'b0;
            finished_reg  <= 1'b0;
            prev_sq_reg   <= '0;
            group_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            max_sq_reg    <= max_sq_next;
            started_reg   <= started_next;
            finished_reg  <= finished_next;
            prev_sq_reg   <= prev_sq_next;
            group_reg     <= group_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result and output payload.
    always_ff @(posedge clk)
    begin
        res_row_reg     <= res_row_next;
        res_col_reg     <= res_col_next;
        res_sq_reg      <= res_sq_next;
        res_grp_reg     <= res_grp_next;
        res_gstart_reg  <= res_gstart_next;
        res_last_reg    <= res_last_next;
        res_valid_reg   <= res_valid_next;
        row_offset_reg  <= row_offset_next;
        col_offset_reg  <= col_offset_next;
        sq_dist_reg     <= sq_dist_next;
        group_index_reg <= group_index_next;
        group_start_reg <= group_start_next;
        last_point_reg  <= last_point_next;
        point_valid_reg <= point_valid_next;
    end

    assign out_valid   = out_valid_reg;
    assign row_offset  = row_offset_reg;
    assign col_offset  = col_offset_reg;
    assign sq_dist     = sq_dist_reg;
    assign group_index = group_index_reg;
    assign group_start = group_start_reg;
    assign last_point  = last_point_reg;
    assign point_valid = point_valid_reg;

`ifndef SYNTHESIS
    // The chain minimum taken at select time lies inside the current bound.
    a_tail_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK && tail_valid) |-> (tail_sq <= SqW'(max_sq_reg)))
        else $error("chain minimum outside the distance bound");

    // A result leaving the output stage returns the sequencer to idle with valid output.
    a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free) |=> (out_valid && state_reg == ST_IDLE))
        else $error("output stage did not take the result");

    // An empty transaction carries zero fields and no last mark.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !point_valid) |->
        (row_offset == '0 && col_offset == '0 && sq_dist == '0 &&
         group_index == '0 && !group_start && !last_point))
        else $error("empty transaction carries data");

    // A row advances only in the select step, with a valid chain minimum and no clear.
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |-> (state_reg == ST_PICK && tail_valid && !clear_all))
        else $error("row update outside select step");
`endif

endmodule

`default_nettype wire
